// ===== design/lgs_pkg.sv =====
// ---------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the life grid stepper
// Item and result layouts, side limits and the operation codes of an item.
// ---------------------------------------------------------------------------
package lgs_pkg;

	// default number of grid columns
	localparam int GRID_SIZE_DEF = 32;
	// widest column that the result carries
	localparam int MAX_SIDE      = 32;
	// smallest side in use
	localparam int MIN_SIDE      = 3;
	// side in use after reset
	localparam logic [5:0] SIZE_RESET = 6'd32;

	// item operation codes
	localparam logic MODE_TOGGLE = 1'b0;
	localparam logic MODE_STEP   = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [4:0] x_pos;
		logic [4:0] y_pos;
	} item_t;

	typedef struct packed {
		logic [4:0]  column_index;
		logic [31:0] column_cells;
		logic        rejected;
		logic        last_column;
	} result_t;

endpackage

// ===== design/lgs_column_eval.sv =====
// ---------------------------------------------------------------------------
// lgs_column_eval: next generation of one grid column
// Applies the B3/S23 rule to every cell of the middle column of a
// three-column window; rows outside the column count as dead.
// ---------------------------------------------------------------------------
module lgs_column_eval #(
	parameter int ROWS = 32
) (
	input  logic [ROWS-1:0] left,
	input  logic [ROWS-1:0] mid,
	input  logic [ROWS-1:0] right,
	output logic [ROWS-1:0] next
);
	import lgs_pkg::*;

	// count the eight neighbors of each cell and apply the rule
	always_comb begin
		logic [3:0] cnt;
		next = '0;
		for (int r = 0; r < ROWS; r++) begin
			cnt = 4'(left[r]) + 4'(right[r]);
			if (r > 0) begin
				cnt = cnt + 4'(left[r-1]) + 4'(mid[r-1]) + 4'(right[r-1]);
			end
			if (r < ROWS - 1) begin
				cnt = cnt + 4'(left[r+1]) + 4'(mid[r+1]) + 4'(right[r+1]);
			end
			next[r] = (cnt == 4'd3) || (mid[r] && (cnt == 4'd2));
		end
	end

endmodule

// ===== design/life_grid_stepper.sv =====
// ---------------------------------------------------------------------------
// life_grid_stepper: Conway Life (B3/S23) grid with toggle and step items
// Keeps the grid in a column memory; a step sweeps it with a window of
// three columns through one shared column evaluator.
// ---------------------------------------------------------------------------
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  item     | item_valid, item_ready, item     | toggle or step request
//  result   | result_valid, result_ready, result | one grid column per transfer
//  cfg      | cfg_valid, cfg_ready, cfg_data   | side in use (always ready)
//
// A toggle does a memory read, then a read-modify-write of one column.
// A step for side n does one read to prime the window, one to fill it, then
// one column per cycle unless results stall, set by the single memory read port.
// Reset clears the column valid bits, so the grid reads as all dead at once.
// A stalled result holds the sweep; item_ready is low until the item is done.
// ---------------------------------------------------------------------------
module life_grid_stepper #(
	parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  lgs_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output lgs_pkg::result_t result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [5:0]      cfg_data
);
	import lgs_pkg::*;

	localparam int COLS = (GRID_SIZE < MAX_SIDE) ? GRID_SIZE : MAX_SIDE;
	localparam int CW   = $clog2(COLS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_TOGG  = 2'd3;

	logic [1:0]      state_q;
	logic [5:0]      size_q;
	logic [5:0]      side;
	logic [COLS-1:0] row_mask;
	logic [COLS-1:0] valid_q;
	logic [COLS-1:0] mem [COLS];
	logic [COLS-1:0] rdata_q;
	logic            rhit_q;
	logic            mem_re;
	logic            mem_we;
	logic [5:0]      rd_addr;
	logic            rd_ok;
	logic [COLS-1:0] wdata;
	logic [CW-1:0]   waddr;
	logic [COLS-1:0] rd_col;
	logic [COLS-1:0] left_q;
	logic [COLS-1:0] mid_q;
	logic [COLS-1:0] right_col;
	logic [COLS-1:0] next_col;
	logic [4:0]      cx_q;
	logic [4:0]      x_q;
	logic [4:0]      y_q;
	logic            advance;
	logic            accept;
	logic            tog_reject;
	logic            last;
	logic [COLS-1:0] tog_col;
	result_t         res_q;
	logic            res_valid_q;

	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign advance      = !res_valid_q || result_ready;

	// saturate the configured side to the grid limits
	always_comb begin
		side = size_q;
		if (size_q < 6'(MIN_SIDE)) begin
			side = 6'(MIN_SIDE);
		end else if (size_q > 6'(COLS)) begin
			side = 6'(COLS);
		end
	end

	always_comb begin
		for (int r = 0; r < COLS; r++) begin
			row_mask[r] = (6'(r) < side);
		end
	end

	// hold the side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// pick the read address and whether the column holds written data
	always_comb begin
		rd_addr = 6'd0;
		rd_ok   = 1'b0;
		mem_re  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item.mode == MODE_STEP) begin
					rd_addr = 6'd0;
					rd_ok   = valid_q[0];
				end else begin
					rd_addr = {1'b0, item.x_pos};
					rd_ok   = (rd_addr < 6'(COLS)) && valid_q[rd_addr[CW-1:0]];
				end
				mem_re = accept;
			end
			ST_LOAD: begin
				rd_addr = 6'd1;
				rd_ok   = (rd_addr < side) && valid_q[1];
				mem_re  = 1'b1;
			end
			ST_RUN: begin
				rd_addr = 6'(cx_q) + 6'd2;
				rd_ok   = (rd_addr < side) && valid_q[rd_addr[CW-1:0]];
				mem_re  = advance;
			end
			default: begin
				rd_addr = 6'd0;
				rd_ok   = 1'b0;
				mem_re  = 1'b0;
			end
		endcase
	end

	assign rd_col    = rhit_q ? rdata_q : '0;
	assign right_col = rd_col & row_mask;
	assign last      = ((6'(cx_q) + 6'd1) == side);

	lgs_column_eval #(
		.ROWS(COLS)
	) u_eval (
		.left (left_q),
		.mid  (mid_q),
		.right(right_col),
		.next (next_col)
	);

	// toggle result: flip one cell unless outside the square
	assign tog_reject = ({1'b0, x_q} >= side) || ({1'b0, y_q} >= side);
	assign tog_col    = tog_reject ? rd_col : (rd_col ^ (COLS'(1) << y_q));

	// pick the write-back column
	always_comb begin
		mem_we = 1'b0;
		wdata  = next_col & row_mask;
		waddr  = cx_q[CW-1:0];
		if (state_q == ST_RUN) begin
			mem_we = advance;
		end else if (state_q == ST_TOGG) begin
			mem_we = advance && !tog_reject;
			wdata  = tog_col;
			waddr  = x_q[CW-1:0];
		end
	end

	// column memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[rd_addr[CW-1:0]];
			rhit_q  <= rd_ok;
		end
	end

	// track written columns; drop columns beyond the side when a step starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (accept && (item.mode == MODE_STEP)) begin
				for (int i = 0; i < COLS; i++) begin
					if (6'(i) >= side) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
			if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (item.mode == MODE_STEP) ? ST_LOAD : ST_TOGG;
					end
				end
				ST_LOAD: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (advance && last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TOGG: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window, column counter and captured coordinates
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= item.x_pos;
			y_q <= item.y_pos;
		end
		if (state_q == ST_LOAD) begin
			left_q <= '0;
			mid_q  <= right_col;
			cx_q   <= 5'd0;
		end else if ((state_q == ST_RUN) && advance) begin
			left_q <= mid_q;
			mid_q  <= right_col;
			cx_q   <= cx_q + 5'd1;
		end
	end

	// result register: load on advance, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && ((state_q == ST_RUN) || (state_q == ST_TOGG))) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (state_q == ST_RUN)) begin
			res_q.column_index <= cx_q;
			res_q.column_cells <= 32'(next_col & row_mask);
			res_q.rejected     <= 1'b0;
			res_q.last_column  <= last;
		end else if (advance && (state_q == ST_TOGG)) begin
			res_q.column_index <= x_q;
			res_q.column_cells <= 32'(tog_col);
			res_q.rejected     <= tog_reject;
			res_q.last_column  <= 1'b1;
		end
	end

endmodule

// ===== tb/life_grid_stepper_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_grid_stepper_tb: self-checking bench for the Life grid stepper
// Keeps its own copy of the grid and the side in use, and works out every
// column that toggle and step items must return. Opens with corner and edge
// cases, then runs random phases at several sides with bursty items and
// stalled results. Each returned column is compared field by field.
// ---------------------------------------------------------------------------
module life_grid_stepper_tb;
	import lgs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SIDE_LIMIT  = (GRID_SIZE_DEF < MAX_SIDE) ? GRID_SIZE_DEF : MAX_SIDE;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data     = '0;

	// grid and side as the block should hold them
	logic [31:0] grid_model [0:31];
	logic [5:0]  side_reg;

	item_t       pending_items [$];
	result_t     expected_columns [$];

	int          items_pushed   = 0;
	int          items_taken    = 0;
	int          columns_seen   = 0;
	int          steps_seen     = 0;
	int          rejects_seen   = 0;
	int          side_writes    = 0;
	int          fail_count     = 0;
	int          cycle_count    = 0;
	bit          item_predicted = 1'b0;
	bit          item_taken_q   = 1'b0;

	// traffic shaping, set per phase
	bit          sender_bursty  = 1'b0;
	int          sink_mode      = 0;
	int          burst_left     = 0;
	int          gap_left       = 0;
	int          sink_phase     = 0;

	life_grid_stepper u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// clamp a register value to the side actually used
	function automatic int effective_side(logic [5:0] v);
		int n;
		n = int'(v);
		if (n < MIN_SIDE) n = MIN_SIDE;
		if (n > SIDE_LIMIT) n = SIDE_LIMIT;
		return n;
	endfunction

	// apply one item to the grid copy and queue the columns it returns
	task automatic predict_item(item_t it);
		int          n;
		int          cnt;
		int          ry;
		logic [31:0] mask;
		logic [31:0] left_col;
		logic [31:0] mid_col;
		logic [31:0] right_col;
		logic [31:0] next_grid [0:31];
		result_t     r;
		n = effective_side(side_reg);
		if (it.mode == MODE_TOGGLE) begin
			r.column_index = it.x_pos;
			r.last_column  = 1'b1;
			if (it.x_pos >= n || it.y_pos >= n) begin
				// outside the square: report the column untouched
				r.rejected = 1'b1;
				rejects_seen++;
			end else begin
				grid_model[it.x_pos][it.y_pos] = ~grid_model[it.x_pos][it.y_pos];
				r.rejected = 1'b0;
			end
			r.column_cells = grid_model[it.x_pos];
			expected_columns.push_back(r);
		end else begin
			steps_seen++;
			mask = (n >= 32) ? '1 : ((32'h1 << n) - 32'h1);
			for (int cx = 0; cx < 32; cx++) begin
				next_grid[cx] = '0;
			end
			// count neighbors with everything outside the square dead
			for (int cx = 0; cx < n; cx++) begin
				left_col  = (cx > 0) ? (grid_model[cx - 1] & mask) : '0;
				mid_col   = grid_model[cx] & mask;
				right_col = (cx + 1 < n) ? (grid_model[cx + 1] & mask) : '0;
				for (int cy = 0; cy < n; cy++) begin
					cnt = 0;
					for (int dy = -1; dy <= 1; dy++) begin
						ry = cy + dy;
						if (ry >= 0 && ry < n) begin
							cnt += int'(left_col[ry]) + int'(right_col[ry]);
							if (dy != 0) cnt += int'(mid_col[ry]);
						end
					end
					next_grid[cx][cy] = (cnt == 3) || (mid_col[cy] && cnt == 2);
				end
			end
			for (int cx = 0; cx < 32; cx++) begin
				grid_model[cx] = next_grid[cx];
			end
			for (int cx = 0; cx < n; cx++) begin
				r.column_index = cx[4:0];
				r.column_cells = grid_model[cx];
				r.rejected     = 1'b0;
				r.last_column  = (cx == n - 1);
				expected_columns.push_back(r);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	// compare one returned column with the oldest expectation
	task automatic check_column(result_t got);
		result_t want;
		if (expected_columns.size() == 0) begin
			report_mismatch($sformatf("column %0d returned with nothing expected",
				got.column_index));
			return;
		end
		want = expected_columns.pop_front();
		if (got.column_index !== want.column_index)
			report_mismatch($sformatf("column_index got %0d want %0d",
				got.column_index, want.column_index));
		if (got.column_cells !== want.column_cells)
			report_mismatch($sformatf("column %0d cells got %h want %h",
				want.column_index, got.column_cells, want.column_cells));
		if (got.rejected !== want.rejected)
			report_mismatch($sformatf("column %0d rejected got %b want %b",
				want.column_index, got.rejected, want.rejected));
		if (got.last_column !== want.last_column)
			report_mismatch($sformatf("column %0d last_column got %b want %b",
				want.column_index, got.last_column, want.last_column));
	endtask

	// ------------------------------------------------------------------
	// monitor: sample transfers at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int cx = 0; cx < 32; cx++) begin
				grid_model[cx] = '0;
			end
			side_reg       = SIZE_RESET;
			item_predicted = 1'b0;
			item_taken_q   = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				side_reg = cfg_data;
			end
			// predict once the item is presented; results may stream before it is taken
			if (item_valid && !item_predicted) begin
				predict_item(item);
				item_predicted = 1'b1;
			end
			item_taken_q = item_valid && item_ready;
			if (item_taken_q) begin
				item_predicted = 1'b0;
				items_taken++;
			end
			if (result_valid && result_ready) begin
				columns_seen++;
				check_column(result);
			end
		end
	end

	// ------------------------------------------------------------------
	// driver: feed items, in bursts when the phase asks, change inputs at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(item_valid && !item_taken_q)) begin
			if (gap_left > 0 || pending_items.size() == 0) begin
				item_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end else begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
				if (sender_bursty) begin
					if (burst_left == 0) burst_left = $urandom_range(1, 6);
					burst_left--;
					if (burst_left == 0) gap_left = $urandom_range(1, 5);
				end
			end
		end
	end

	// stall results on a pattern chosen per phase
	always @(negedge clk) begin
		sink_phase++;
		case (sink_mode)
			0: begin
				result_ready <= 1'b1;
			end
			1: begin
				result_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				result_ready <= ((sink_phase % 5) >= 2);
			end
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d columns still expected",
				cycle_count, expected_columns.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	task automatic add_item(logic mode, int x, int y);
		item_t it;
		it.mode  = mode;
		it.x_pos = x[4:0];
		it.y_pos = y[4:0];
		pending_items.push_back(it);
		items_pushed++;
	endtask

	task automatic add_step();
		add_item(MODE_STEP, $urandom_range(0, 31), $urandom_range(0, 31));
	endtask

	// hold until every item is taken and every column returned
	task automatic wait_idle();
		do @(negedge clk);
		while (!(items_taken == items_pushed && expected_columns.size() == 0));
		repeat (4) @(negedge clk);
	endtask

	task automatic write_side(logic [5:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		side_writes++;
	endtask

	// mostly toggles inside the square with steps between, plus stray toggles
	task automatic add_random_items(int count, int n);
		int pick;
		int wx;
		int wy;
		wx = $urandom_range(0, n - 3);
		wy = $urandom_range(0, n - 3);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				add_step();
			end else if (pick < 25) begin
				add_item(MODE_TOGGLE, $urandom_range(0, 31), $urandom_range(0, 31));
			end else if (pick < 60) begin
				// seed a small patch so patterns form
				add_item(MODE_TOGGLE, wx + $urandom_range(0, 2), wy + $urandom_range(0, 2));
			end else begin
				add_item(MODE_TOGGLE, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
			end
		end
	endtask

	initial begin
		logic [5:0] phase_side [0:8];
		phase_side[0] = 6'd63;
		phase_side[1] = 6'd2;
		phase_side[2] = 6'd33;
		phase_side[3] = 6'd7;
		phase_side[4] = 6'd32;
		phase_side[5] = 6'($urandom_range(3, 12));
		phase_side[6] = 6'($urandom_range(3, 12));
		phase_side[7] = 6'($urandom_range(3, 12));
		phase_side[8] = 6'($urandom_range(0, 63));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners at reset side: dead-border counting, lone cells dying
		sink_mode = 1;
		add_item(MODE_TOGGLE, 0, 0);
		add_item(MODE_TOGGLE, 1, 0);
		add_item(MODE_TOGGLE, 0, 1);
		add_item(MODE_TOGGLE, 31, 31);
		add_item(MODE_TOGGLE, 30, 31);
		add_item(MODE_TOGGLE, 31, 30);
		add_item(MODE_TOGGLE, 0, 31);
		add_item(MODE_TOGGLE, 15, 16);
		add_step();
		add_step();
		add_item(MODE_TOGGLE, 0, 0);
		wait_idle();

		// smallest side: out-of-square toggles, leftover cells, blinker
		write_side(6'd0);
		sink_mode = 2;
		add_item(MODE_TOGGLE, 3, 0);
		add_item(MODE_TOGGLE, 0, 3);
		add_item(MODE_TOGGLE, 31, 31);
		add_item(MODE_TOGGLE, 1, 0);
		add_item(MODE_TOGGLE, 1, 1);
		add_item(MODE_TOGGLE, 1, 2);
		add_step();
		add_step();
		add_item(MODE_TOGGLE, 31, 0);
		add_item(MODE_TOGGLE, 2, 2);
		add_step();
		wait_idle();

		// random phases over several sides and traffic patterns
		for (int p = 0; p < 9; p++) begin
			write_side(phase_side[p]);
			sink_mode     = p % 3;
			sender_bursty = (p % 2 == 1) || (p == 8);
			add_random_items(18, effective_side(phase_side[p]));
			wait_idle();
		end

		repeat (8) @(negedge clk);
		if (expected_columns.size() != 0)
			report_mismatch($sformatf("%0d columns never returned", expected_columns.size()));

		$display("Ran %0d items (%0d generation steps, %0d rejected toggles) at %0d sides",
			items_pushed, steps_seen, rejects_seen, side_writes + 1);
		$display("Checked %0d returned columns, %0d mismatches", columns_seen, fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
